/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, c, r, a, b, msg) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, c, r, a, b, msg) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (a) |=> (b)) else $error(msg);

`endif

/* sv/imu_cal_pkg.sv */
// ----------------------------------------------------------------------------
// imu_cal_pkg
// types, codes and widths shared by the imu scale and gyro bias calibration
// ----------------------------------------------------------------------------
`default_nettype none

package imu_cal_pkg;

  localparam int FRAC_BITS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam int RAW_W  = 16;
  localparam int GYRO_W = 25;
  localparam int BIAS_W = 24;
  localparam int CFG_W  = 16;

  localparam logic [CFG_W-1:0] CALIB_SAMPLES_RST = 16'd100;
  localparam int               GYRO_LIM          = 16777215;

  localparam int IN_TDATA_W  = 6 * RAW_W;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_PAY_W   = 3 * RAW_W + 3 * GYRO_W + 3 * BIAS_W;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RDERR  = 3'd1,
    ST_CALIB  = 3'd2,
    ST_DONE   = 3'd3,
    ST_FAIL   = 3'd4,
    ST_BADCNT = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIVLD,
    S_DIV,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_START,
    OP_ACCUM
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    op_t     op;
    logic    set_status;
    status_t status;
    logic    div_start;
    logic    div_step;
    logic    div_write;
    logic    load_out;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd;
    logic ok;
    logic cal;
    logic cnt_zero;
    logic last;
    logic good_next_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/imu_cal_ctrl.sv */
// ----------------------------------------------------------------------------
// imu_cal_ctrl
// sequencer: takes one item, decides its status and the state update,
// runs the bias divider on a last calibration attempt with good samples, emits the result
// ----------------------------------------------------------------------------
`default_nettype none

module imu_cal_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire imu_cal_pkg::dp_stat_t stat,
  output imu_cal_pkg::ctl_cmd_t     cmd
);
  import imu_cal_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd.load_in    = 1'b0;
    cmd.op         = OP_NONE;
    cmd.set_status = 1'b0;
    cmd.status     = ST_OK;
    cmd.div_start  = 1'b0;
    cmd.div_step   = 1'b0;
    cmd.div_write  = 1'b0;
    cmd.load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_EMIT;
        if (stat.cmd) begin
          if (stat.cnt_zero) begin
            cmd.status = ST_BADCNT;
          end else begin
            cmd.op     = OP_START;
            cmd.status = ST_CALIB;
          end
        end else if (stat.cal) begin
          cmd.op     = OP_ACCUM;
          cmd.status = ST_CALIB;
          if (stat.last) begin
            if (stat.good_next_zero) begin
              cmd.status = ST_FAIL;
            end else begin
              cmd.status = ST_DONE;
              state_nxt  = S_DIVLD;
            end
          end
        end else if (!stat.ok) begin
          cmd.status = ST_RDERR;
        end else begin
          cmd.status = ST_OK;
        end
      end
      S_DIVLD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_write = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/imu_cal_dp.sv */
// ----------------------------------------------------------------------------
// imu_cal_dp
// datapath: item register, calibration counters and sums, three-lane
// restoring divider for the biases, gyro correction and output register
// ----------------------------------------------------------------------------
`default_nettype none

module imu_cal_dp #(
  parameter int FRAC_BITS  = imu_cal_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = imu_cal_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [imu_cal_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [imu_cal_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [imu_cal_pkg::CFG_W-1:0]       cfg_data,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [imu_cal_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [imu_cal_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  wire imu_cal_pkg::ctl_cmd_t               cmd,
  output imu_cal_pkg::dp_stat_t                    stat
);
  import imu_cal_pkg::*;

  localparam int SUM_W = RAW_W + COUNT_BITS;
  localparam int DIV_W = SUM_W + FRAC_BITS;
  localparam int DCW   = $clog2(DIV_W + 1);
  localparam int MAG_W = (DIV_W > BIAS_W + 1) ? DIV_W : BIAS_W + 1;
  localparam int GX_W  = ((RAW_W + FRAC_BITS > BIAS_W) ? RAW_W + FRAC_BITS : BIAS_W) + 2;

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (BIAS_W - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (BIAS_W - 1));
  localparam logic signed [GX_W-1:0] GX_HI = GX_W'(GYRO_LIM);
  localparam logic signed [GX_W-1:0] GX_LO = -GX_HI;

  // item register
  logic                    cmd_r;
  logic                    ok_r;
  logic signed [RAW_W-1:0] acc_r [3];
  logic signed [RAW_W-1:0] gyr_r [3];

  // calibration state
  logic [CFG_W-1:0]         cfg_r;
  logic                     cal_r;
  logic [COUNT_BITS-1:0]    att_r;
  logic [COUNT_BITS-1:0]    good_r;
  logic signed [SUM_W-1:0]  sum_r [3];
  logic signed [BIAS_W-1:0] bias_r [3];
  status_t                  status_r;

  // divider
  logic [DIV_W-1:0]      dq_r  [3];
  logic [COUNT_BITS-1:0] rem_r [3];
  logic                  neg_r [3];
  logic [DCW-1:0]        dcnt_r;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  logic [COUNT_BITS-1:0]      good_nxt;
  logic [COUNT_BITS-1:0]      att_nxt;
  logic [COUNT_BITS:0]        trial   [3];
  logic                       qbit    [3];
  logic [COUNT_BITS-1:0]      rem_nxt [3];
  logic [SUM_W-1:0]           mag     [3];
  logic signed [GX_W-1:0]     gx      [3];
  logic signed [GYRO_W-1:0]   gsat    [3];
  logic [OUT_TDATA_W-1:0]     pay;

  function automatic logic signed [BIAS_W-1:0] sat_bias(input logic neg,
                                                       input logic [DIV_W-1:0] q);
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] nm;
    m  = MAG_W'(q);
    nm = -m;
    if (!neg) begin
      sat_bias = (m > POS_LIM) ? POS_LIM[BIAS_W-1:0] : m[BIAS_W-1:0];
    end else begin
      sat_bias = (m > NEG_LIM) ? NEG_LIM[BIAS_W-1:0] : nm[BIAS_W-1:0];
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign good_nxt  = good_r + COUNT_BITS'(ok_r);
  assign att_nxt   = att_r - COUNT_BITS'(1);

  assign stat.cmd            = cmd_r;
  assign stat.ok             = ok_r;
  assign stat.cal            = cal_r;
  assign stat.cnt_zero       = (cfg_r[COUNT_BITS-1:0] == '0);
  assign stat.last           = (att_r == COUNT_BITS'(1));
  assign stat.good_next_zero = (good_nxt == '0);
  assign stat.div_done       = (dcnt_r == '0);
  assign stat.out_free       = !out_valid_r || out_tready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i]   = {rem_r[i], dq_r[i][DIV_W-1]};
      qbit[i]    = (trial[i] >= {1'b0, good_r});
      rem_nxt[i] = qbit[i] ? COUNT_BITS'(trial[i] - {1'b0, good_r})
                           : trial[i][COUNT_BITS-1:0];
      mag[i]     = sum_r[i][SUM_W-1] ? SUM_W'(-sum_r[i]) : SUM_W'(sum_r[i]);
      gx[i]      = (GX_W'(gyr_r[i]) <<< FRAC_BITS) - GX_W'(bias_r[i]);
      if (gx[i] > GX_HI) begin
        gsat[i] = GX_HI[GYRO_W-1:0];
      end else if (gx[i] < GX_LO) begin
        gsat[i] = GX_LO[GYRO_W-1:0];
      end else begin
        gsat[i] = gx[i][GYRO_W-1:0];
      end
    end
  end

  // accel and gyro are zero unless the status is ok
  always_comb begin
    pay = '0;
    for (int i = 0; i < 3; i++) begin
      if (status_r == ST_OK) begin
        pay[i*RAW_W +: RAW_W]                 = acc_r[i];
        pay[3*RAW_W + i*GYRO_W +: GYRO_W]     = gsat[i];
      end
      pay[3*RAW_W + 3*GYRO_W + i*BIAS_W +: BIAS_W] = bias_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CALIB_SAMPLES_RST;
      cal_r       <= 1'b0;
      att_r       <= '0;
      good_r      <= '0;
      status_r    <= ST_OK;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      case (cmd.op)
        OP_START: begin
          cal_r  <= 1'b1;
          att_r  <= cfg_r[COUNT_BITS-1:0];
          good_r <= '0;
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= '0;
          end
        end
        OP_ACCUM: begin
          att_r  <= att_nxt;
          good_r <= good_nxt;
          if (att_nxt == '0) begin
            cal_r <= 1'b0;
          end
          if (ok_r) begin
            for (int i = 0; i < 3; i++) begin
              sum_r[i] <= sum_r[i] + SUM_W'(gyr_r[i]);
            end
          end
        end
        default: begin
        end
      endcase
      if (cmd.div_start) begin
        dcnt_r <= DCW'(DIV_W);
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - DCW'(1);
      end
      if (cmd.div_write) begin
        for (int i = 0; i < 3; i++) begin
          bias_r[i] <= sat_bias(neg_r[i], dq_r[i]);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_tuser[0];
      ok_r  <= in_tuser[1];
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= in_tdata[i*RAW_W +: RAW_W];
        gyr_r[i] <= in_tdata[(3+i)*RAW_W +: RAW_W];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.div_start) begin
        dq_r[i]  <= DIV_W'(mag[i]) << FRAC_BITS;
        rem_r[i] <= '0;
        neg_r[i] <= sum_r[i][SUM_W-1];
      end else if (cmd.div_step) begin
        dq_r[i]  <= {dq_r[i][DIV_W-2:0], qbit[i]};
        rem_r[i] <= rem_nxt[i];
      end
    end
    if (cmd.load_out) begin
      out_data_r <= pay;
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

/* sv/imu_sample_scale_and_gyro_bias_cal.sv */
// ----------------------------------------------------------------------------
// imu_sample_scale_and_gyro_bias_cal
// each item passes from the item register through the status decision to
//   the output register; the last calibration attempt with good samples also
//   runs the bit-serial restoring divider, one quotient bit per cycle, three
//   axes in parallel, before its result is loaded
// flow: one item at a time, next input accepted the cycle after the
//   result is loaded into the output register, which happens only once that
//   register is free
// reset: synchronous active-low rst_n clears mode, counters, sums and biases,
//   and sets calib_samples to 100
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sample_scale_and_gyro_bias_cal #(
  parameter int FRAC_BITS  = imu_cal_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = imu_cal_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // raw accel x, y, z then raw gyro x, y, z
  input  wire logic [imu_cal_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command, read_ok
  input  wire logic [imu_cal_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [imu_cal_pkg::CFG_W-1:0]       cfg_data,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, bias_x, bias_y, bias_z
  output logic [imu_cal_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status
  output logic [imu_cal_pkg::OUT_TUSER_W-1:0]      out_tuser
);
  import imu_cal_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  imu_cal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  imu_cal_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire

/* sv/imu_cal_chk.sv */
// ----------------------------------------------------------------------------
// imu_cal_chk
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module imu_cal_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [imu_cal_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [imu_cal_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import imu_cal_pkg::*;

  localparam int MEAS_W = 3 * RAW_W + 3 * GYRO_W;

  // items taken but not yet delivered
  logic [1:0] pend_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
            out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `CHK_IMPL(a_status_code, clk, rst_n, out_tvalid, out_tuser <= ST_BADCNT, "undefined status code")
  `CHK_IMPL(a_zero_meas, clk, rst_n, out_tvalid && (out_tuser != ST_OK),
            out_tdata[MEAS_W-1:0] == '0, "measurement fields not zero on non-ok status")
  `CHK_IMPL(a_no_extra, clk, rst_n, out_xfer, pend_r != 2'd0, "result without an item")
  `CHK_IMPL(a_pend_bound, clk, rst_n, 1'b1, pend_r != 2'd3, "more than two items in flight")

endmodule

bind imu_sample_scale_and_gyro_bias_cal imu_cal_chk u_chk (.*);

`default_nettype wire

/* tb/sv/imu_sample_scale_and_gyro_bias_cal_tb.sv */
// ----------------------------------------------------------------------------
// imu_sample_scale_and_gyro_bias_cal_tb
// self-checking bench for the imu frame scaler and gyro bias calibration.
// a directed table covers pass-through, read errors, start, zero count,
// failed and completed runs and the reset count; random phases then drive
// calibration runs, restarts, broken runs and noise under several counts.
// the bench ends with one run on full-scale gyro values. each result is
// compared field by field against an in-bench model of the block.
// ----------------------------------------------------------------------------

module imu_sample_scale_and_gyro_bias_cal_tb;
  import imu_cal_pkg::*;

  localparam int     FRAC           = FRAC_BITS_DEF;
  localparam int     RANDOM_ITEMS   = 1400;
  localparam int     FULL_SCALE_RUN = 120;
  localparam int     CYCLE_LIMIT    = 1000000;
  localparam longint BIAS_HI        = 64'sd8388607;
  localparam longint BIAS_LO        = -64'sd8388608;

  // field order matches {in_tuser, in_tdata}
  typedef struct packed {
    logic                  ok;
    logic                  cmd;
    logic [2:0][RAW_W-1:0] gyro;
    logic [2:0][RAW_W-1:0] accel;
  } imu_frame_t;

  // field order matches {out_tuser, out_tdata} without the pad bits
  typedef struct packed {
    status_t                status;
    logic [2:0][BIAS_W-1:0] bias;
    logic [2:0][GYRO_W-1:0] gyro;
    logic [2:0][RAW_W-1:0]  accel;
  } imu_result_t;

  typedef struct {
    bit          fixed;
    imu_result_t want;
  } typed_exp_t;

  typedef enum {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    int               reps;
    logic [CFG_W-1:0] count;
    imu_frame_t       frame;
    bit               fixed;
    imu_result_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  imu_sample_scale_and_gyro_bias_cal uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // calibration model state
  logic [CFG_W-1:0]        samples_cfg   = CALIB_SAMPLES_RST;
  bit                      cal_active    = 1'b0;
  logic [15:0]             attempts_left = '0;
  logic [15:0]             good_seen     = '0;
  longint                  gyro_sum[3]   = '{0, 0, 0};
  logic signed [BIAS_W-1:0] bias_now[3]  = '{0, 0, 0};

  imu_result_t want_queue[$];
  typed_exp_t  typed_queue[$];
  stim_row_t   stim_table[$];

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  sent           = 0;
  int  cycle_count    = 0;
  int  ready_hold     = 0;
  bit  calm           = 1'b0;

  function automatic logic signed [BIAS_W-1:0] average_to_bias(longint sum, longint n);
    longint mag;
    longint q;
    mag = (sum < 0) ? -sum : sum;
    mag = (mag << FRAC) / n;
    if (mag > (longint'(1) << 40)) mag = longint'(1) << 40;
    q = (sum < 0) ? -mag : mag;
    if (q > BIAS_HI) q = BIAS_HI;
    if (q < BIAS_LO) q = BIAS_LO;
    return q[BIAS_W-1:0];
  endfunction

  // advances the model by one accepted frame and returns its result
  function automatic imu_result_t predict_frame(imu_frame_t f);
    imu_result_t r;
    longint      g;
    int          i;
    r = '0;
    if (f.cmd) begin
      if (samples_cfg == 0) begin
        r.status = ST_BADCNT;
      end else begin
        cal_active    = 1'b1;
        attempts_left = samples_cfg;
        good_seen     = '0;
        for (i = 0; i < 3; i++) gyro_sum[i] = 0;
        r.status = ST_CALIB;
      end
    end else if (cal_active) begin
      if (f.ok) begin
        for (i = 0; i < 3; i++) gyro_sum[i] += longint'($signed(f.gyro[i]));
        good_seen++;
      end
      attempts_left--;
      r.status = ST_CALIB;
      if (attempts_left == 0) begin
        cal_active = 1'b0;
        if (good_seen == 0) begin
          r.status = ST_FAIL;
        end else begin
          for (i = 0; i < 3; i++)
            bias_now[i] = average_to_bias(gyro_sum[i], longint'(good_seen));
          r.status = ST_DONE;
        end
      end
    end else if (!f.ok) begin
      r.status = ST_RDERR;
    end else begin
      r.status = ST_OK;
      for (i = 0; i < 3; i++) begin
        r.accel[i] = f.accel[i];
        g = longint'($signed(f.gyro[i])) * (longint'(1) << FRAC) - longint'(bias_now[i]);
        if (g > GYRO_LIM) g = GYRO_LIM;
        if (g < -GYRO_LIM) g = -GYRO_LIM;
        r.gyro[i] = g[GYRO_W-1:0];
      end
    end
    for (i = 0; i < 3; i++) r.bias[i] = bias_now[i];
    return r;
  endfunction

  task automatic compare_result(imu_result_t got, imu_result_t want);
    string where;
    int    i;
    where = "";
    if (got.status !== want.status) where = {where, " status"};
    for (i = 0; i < 3; i++) begin
      if (got.accel[i] !== want.accel[i]) where = {where, $sformatf(" accel[%0d]", i)};
      if (got.gyro[i] !== want.gyro[i]) where = {where, $sformatf(" gyro[%0d]", i)};
      if (got.bias[i] !== want.bias[i]) where = {where, $sformatf(" bias[%0d]", i)};
    end
    if (where != "") begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display({"result %0d wrong in%s: want st=%0d acc=%h gyr=%h bias=%h",
                  "\n  got st=%0d acc=%h gyr=%h bias=%h"},
                 results_seen, where, want.status, want.accel, want.gyro, want.bias,
                 got.status, got.accel, got.gyro, got.bias);
    end
  endtask

  // model update and result checking
  always @(posedge clk) begin
    imu_result_t got;
    imu_result_t want;
    typed_exp_t  tx;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) samples_cfg = cfg_data;
      if (in_tvalid && in_tready) begin
        want = predict_frame(imu_frame_t'({in_tuser, in_tdata}));
        tx = typed_queue.pop_front();
        if (tx.fixed) want = tx.want;
        want_queue.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = imu_result_t'({out_tuser, out_tdata[OUT_PAY_W-1:0]});
        if (want_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with no input transfer pending: st=%0d",
                     results_seen, got.status);
        end else begin
          compare_result(got, want_queue.pop_front());
        end
        results_seen++;
      end
    end
  end

  // result side: out_tready alternates ready runs and stall bursts, always ready once calm is set
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (calm || !out_tready || $urandom_range(0, 2) != 0) begin
      out_tready <= 1'b1;
      ready_hold = calm ? 0 : $urandom_range(0, 30);
    end else begin
      out_tready <= 1'b0;
      ready_hold = $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic imu_frame_t make_frame(logic cmd, logic ok,
                                            logic [RAW_W-1:0] ax, logic [RAW_W-1:0] ay,
                                            logic [RAW_W-1:0] az, logic [RAW_W-1:0] gx,
                                            logic [RAW_W-1:0] gy, logic [RAW_W-1:0] gz);
    imu_frame_t f;
    f.cmd   = cmd;
    f.ok    = ok;
    f.accel = {az, ay, ax};
    f.gyro  = {gz, gy, gx};
    return f;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return RAW_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic imu_frame_t random_frame();
    imu_frame_t f;
    int         i;
    f.cmd = 1'b0;
    f.ok  = ($urandom_range(0, 7) != 0);
    for (i = 0; i < 3; i++) begin
      f.accel[i] = pick_raw();
      f.gyro[i]  = pick_raw();
    end
    return f;
  endfunction

  task automatic add_frame(int reps, imu_frame_t f, bit fixed, imu_result_t want);
    stim_row_t row;
    row.kind  = ROW_FRAME;
    row.reps  = reps;
    row.count = '0;
    row.frame = f;
    row.fixed = fixed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  task automatic add_cfg(logic [CFG_W-1:0] v);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.reps  = 0;
    row.count = v;
    row.frame = '0;
    row.fixed = 1'b0;
    row.want  = '0;
    stim_table.push_back(row);
  endtask

  task automatic send_frame(imu_frame_t f, bit fixed, imu_result_t want);
    int         gap;
    typed_exp_t tx;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tx.fixed = fixed;
    tx.want  = want;
    typed_queue.push_back(tx);
    in_tvalid <= 1'b1;
    {in_tuser, in_tdata} <= f;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (want_queue.size() != 0 || typed_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_noise(int n);
    repeat (n) send_frame(random_frame(), 1'b0, '0);
  endtask

  task automatic send_start();
    imu_frame_t f;
    f = random_frame();
    f.cmd = 1'b1;
    f.ok  = 1'($urandom_range(0, 1));
    send_frame(f, 1'b0, '0);
  endtask

  // start followed by a full run of attempts, with an occasional restart
  task automatic run_calibration(int attempts);
    int left;
    send_start();
    left = attempts;
    while (left > 0) begin
      if ($urandom_range(1, 40) == 1) begin
        send_start();
        left = attempts;
      end
      send_noise(1);
      left--;
    end
  endtask

  initial begin
    imu_frame_t  f;
    imu_frame_t  fa;
    imu_result_t ra;
    stim_row_t   row;
    int          p;
    int          n;
    int          pick;
    int          phase_end;
    int          i;
    int          preset[8];

    preset = '{1, 0, 5, 2, 24, 3, 13, 8};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // extremes in normal mode with zero bias
    fa = make_frame(1'b0, 1'b1, 16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF);
    ra = '0;
    ra.status = ST_OK;
    ra.accel  = fa.accel;
    ra.gyro   = {25'h1FFFF00, 25'h1800000, 25'h07FFF00};
    add_frame(1, fa, 1'b1, ra);
    ra = '0;
    ra.status = ST_RDERR;
    add_frame(1, make_frame(1'b0, 1'b0, 16'h1234, 16'hFFFF, 16'h8000,
                            16'h7FFF, 16'h0000, 16'hFFFF), 1'b1, ra);
    ra.status = ST_CALIB;
    add_frame(1, make_frame(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, ra);
    // run at the reset count
    add_frame(100, make_frame(1'b0, 1'b1, 16'h4000, 16'h0000, 16'hC000,
                              16'h0005, 16'hFFF9, 16'h012C), 1'b0, '0);
    add_frame(1, fa, 1'b0, '0);
    // no good samples keeps the bias
    add_cfg(16'd2);
    add_frame(1, make_frame(1'b1, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0);
    add_frame(2, make_frame(1'b0, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, '0);
    // zero count start mid-run, negative average truncated toward zero
    add_cfg(16'd3);
    add_frame(1, make_frame(1'b1, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0);
    add_frame(1, make_frame(1'b0, 1'b1, 16'h0, 16'h0, 16'h0,
                            16'h7FFF, 16'h0000, 16'hFFFF), 1'b0, '0);
    add_cfg(16'd0);
    add_frame(1, make_frame(1'b1, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0);
    add_frame(1, make_frame(1'b0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0);
    add_frame(1, make_frame(1'b0, 1'b1, 16'h0, 16'h0, 16'h0,
                            16'h8000, 16'hFFFF, 16'hFFFE), 1'b0, '0);
    // read error on the last attempt
    add_cfg(16'd2);
    add_frame(1, make_frame(1'b1, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0);
    add_frame(1, make_frame(1'b0, 1'b1, 16'h0100, 16'h0200, 16'h0300,
                            16'h0064, 16'hFF9C, 16'h0007), 1'b0, '0);
    add_frame(1, make_frame(1'b0, 1'b0, 16'h0, 16'h0, 16'h0,
                            16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, '0);
    // restart during a run
    add_frame(1, make_frame(1'b1, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0);
    add_frame(1, make_frame(1'b0, 1'b1, 16'h0, 16'h0, 16'h0,
                            16'h1000, 16'h1000, 16'h1000), 1'b0, '0);
    add_frame(1, make_frame(1'b1, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0);
    add_frame(2, make_frame(1'b0, 1'b1, 16'hAAAA, 16'h5555, 16'h0F0F,
                            16'hFFF0, 16'h0011, 16'hFFFD), 1'b0, '0);
    add_frame(1, fa, 1'b0, '0);

    foreach (stim_table[k]) begin
      row = stim_table[k];
      if (row.kind == ROW_CFG) begin
        write_count(row.count);
      end else begin
        repeat (row.reps) send_frame(row.frame, row.fixed, row.want);
      end
    end

    // random phases, each under its own count
    p = 0;
    while (sent < RANDOM_ITEMS) begin
      n = (p < 8) ? preset[p] : $urandom_range(1, 24);
      write_count(CFG_W'(n));
      phase_end = sent + 170;
      while (sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          run_calibration(n);
          send_noise($urandom_range(0, 3));
        end else if (pick == 7) begin
          send_noise($urandom_range(1, 6));
        end else if (pick == 8) begin
          // broken run, the next start restarts it
          send_start();
          send_noise($urandom_range(0, n));
        end else begin
          drain_results();
          send_noise($urandom_range(1, 4));
        end
      end
      p++;
    end

    calm = 1'b1;
    n = $urandom_range(1, 12);
    write_count(CFG_W'(n));
    phase_end = sent + 150;
    while (sent < phase_end) begin
      run_calibration(n);
      send_noise($urandom_range(0, 3));
    end

    // full-scale gyro averages, then extreme gyro output
    write_count(CFG_W'(FULL_SCALE_RUN));
    send_start();
    for (i = 0; i < FULL_SCALE_RUN; i++) begin
      f = random_frame();
      f.ok      = 1'b1;
      f.gyro[0] = 16'h8000;
      f.gyro[1] = 16'h7FFF;
      send_frame(f, 1'b0, '0);
    end
    for (i = 0; i < 20; i++) begin
      f = random_frame();
      f.ok      = 1'b1;
      f.gyro[0] = (i % 2 == 0) ? 16'h7FFF : 16'h8000;
      f.gyro[1] = (i % 2 == 0) ? 16'h8000 : 16'h7FFF;
      send_frame(f, 1'b0, '0);
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && want_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/imu_cal_pkg.sv
sv/imu_cal_ctrl.sv
sv/imu_cal_dp.sv
sv/imu_sample_scale_and_gyro_bias_cal.sv
sv/imu_cal_chk.sv
tb/sv/imu_sample_scale_and_gyro_bias_cal_tb.sv
